FILE: rtl/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg: shared types and constants of the URL percent decoder
// Character codes, item classes, the escape phase encoding and the item record
// that travels from the front part to the back part.
// ----------------------------------------------------------------------------
`default_nettype none

package upd_pkg;

    // Upper bound on the decoded length of one string.
    localparam longint unsigned MAX_LENGTH = 65535;

    // The counter is 16 bits wide, so the bound is clipped to what it can hold.
    localparam logic [15:0] COUNT_LIMIT =
        (MAX_LENGTH > 64'd65535) ? 16'hFFFF : 16'(MAX_LENGTH);

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_0       = 8'h30;
    localparam logic [7:0] CHAR_9       = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;
    localparam logic [3:0] NIBBLE_TEN   = 4'd10;

    // Class of one encoded character, decided without the escape state.
    typedef enum logic [1:0] {
        KIND_PLAIN   = 2'd0,
        KIND_PERCENT = 2'd1,
        KIND_SPACE   = 2'd2,
        KIND_NUL     = 2'd3
    } item_kind_t;

    // Escape phase of the back part.
    typedef enum logic [2:0] {
        PH_LOOK   = 3'b001,
        PH_FIRST  = 3'b010,
        PH_SECOND = 3'b100
    } escape_phase_t;

    // One classified item as held in the queue.
    typedef struct packed {
        item_kind_t  kind;
        logic [7:0]  data;
        logic [3:0]  nibble;
        logic        last;
    } upd_item_t;

    // Hex value of a character; anything that is not a hex digit counts as 0.
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] diff;
        begin
            diff = 8'd0;
            if (c >= CHAR_0 && c <= CHAR_9)
            begin
                diff = c - CHAR_0;
                nibble_of = diff[3:0];
            end
            else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
            begin
                diff = c - CHAR_UPPER_A;
                nibble_of = diff[3:0] + NIBBLE_TEN;
            end
            else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
            begin
                diff = c - CHAR_LOWER_A;
                nibble_of = diff[3:0] + NIBBLE_TEN;
            end
            else
            begin
                nibble_of = 4'd0;
            end
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/upd_front.sv
// ----------------------------------------------------------------------------
// upd_front: input classification
// Holds the form-mode register, classifies each accepted character and
// extracts its hex value, and hands the result to the item queue.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_front
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output      logic             cfg_ready,
    input  wire logic             plus_as_space,
    input  wire logic             push,
    output      logic             full,
    input  wire logic [7:0]       in_byte,
    input  wire logic             last_byte,
    input  wire logic             q_full,
    output      logic             q_wr,
    output      upd_pkg::upd_item_t q_wr_item
);

    logic form_mode_reg;
    logic form_mode_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        form_mode_next = form_mode_reg;
        if (cfg_valid)
        begin
            form_mode_next = plus_as_space;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            form_mode_reg <= 1'b0;
        end
        else
        begin
            form_mode_reg <= form_mode_next;
        end
    end

    assign full = q_full;
    assign q_wr = push && !q_full;

    always_comb
    begin
        q_wr_item.data   = in_byte;
        q_wr_item.last   = last_byte;
        q_wr_item.nibble = upd_pkg::nibble_of(in_byte);
        priority if (in_byte == upd_pkg::CHAR_NUL)
        begin
            q_wr_item.kind = upd_pkg::KIND_NUL;
        end
        else if (in_byte == upd_pkg::CHAR_PERCENT)
        begin
            q_wr_item.kind = upd_pkg::KIND_PERCENT;
        end
        else if (in_byte == upd_pkg::CHAR_PLUS && form_mode_reg)
        begin
            q_wr_item.kind = upd_pkg::KIND_SPACE;
        end
        else
        begin
            q_wr_item.kind = upd_pkg::KIND_PLAIN;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/upd_queue.sv
// ----------------------------------------------------------------------------
// upd_queue: item queue between front and back
// A small circular buffer of classified items; the oldest one is always
// visible at the read side.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_queue
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr,
    input  wire upd_pkg::upd_item_t wr_item,
    output      logic               q_full,
    input  wire logic               rd,
    output      logic               rd_valid,
    output      upd_pkg::upd_item_t rd_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    upd_pkg::upd_item_t entries [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             do_wr;
    logic             do_rd;

    assign q_full   = (fill_reg == FULL_CNT);
    assign rd_valid = (fill_reg != '0);
    assign rd_item  = entries[rd_ptr_reg];
    assign do_wr    = wr && !q_full;
    assign do_rd    = rd && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/upd_back.sv
// ----------------------------------------------------------------------------
// upd_back: escape decoding and result register
// Tracks the escape phase, assembles escaped bytes, counts decoded characters
// and holds the next result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_back
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire upd_pkg::upd_item_t q_item,
    output      logic               q_rd,
    output      logic               empty,
    input  wire logic               pop,
    output      logic               byte_valid,
    output      logic [7:0]         out_byte,
    output      logic               terminator_written,
    output      logic               done_res,
    output      logic [15:0]        decoded_length
);

    upd_pkg::escape_phase_t phase_reg;
    upd_pkg::escape_phase_t phase_next;
    logic [3:0]             high_nibble_reg;
    logic [3:0]             high_nibble_next;
    logic [15:0]            char_count_reg;
    logic [15:0]            char_count_next;
    logic                   res_valid_reg;
    logic                   res_valid_next;

    logic                   have;
    logic [7:0]             ch;
    logic [15:0]            count_bumped;
    logic                   emit;

    logic                   res_byte_valid_reg;
    logic [7:0]             res_byte_reg;
    logic                   res_term_reg;
    logic                   res_done_reg;
    logic [15:0]            res_length_reg;

    // An item leaves the queue whenever the result slot is free or emptying.
    assign q_rd = q_valid && (!res_valid_reg || pop);

    always_comb
    begin
        have             = 1'b0;
        ch               = 8'd0;
        phase_next       = phase_reg;
        high_nibble_next = high_nibble_reg;
        unique case (phase_reg)
            upd_pkg::PH_FIRST:
            begin
                high_nibble_next = q_item.nibble;
                phase_next       = upd_pkg::PH_SECOND;
            end
            upd_pkg::PH_SECOND:
            begin
                ch         = {high_nibble_reg, q_item.nibble};
                have       = 1'b1;
                phase_next = upd_pkg::PH_LOOK;
            end
            default:
            begin
                phase_next = upd_pkg::PH_LOOK;
                unique case (q_item.kind)
                    upd_pkg::KIND_PERCENT:
                    begin
                        phase_next = upd_pkg::PH_FIRST;
                    end
                    upd_pkg::KIND_SPACE:
                    begin
                        ch   = upd_pkg::CHAR_SPACE;
                        have = 1'b1;
                    end
                    default:
                    begin
                        ch   = q_item.data;
                        have = 1'b1;
                    end
                endcase
            end
        endcase

        count_bumped = char_count_reg;
        if (have && char_count_reg < upd_pkg::COUNT_LIMIT)
        begin
            count_bumped = char_count_reg + 16'd1;
        end
        char_count_next = count_bumped;
        emit            = have || q_item.last;

        // A zero byte overrides all decoding and ends the string.
        if (q_item.kind == upd_pkg::KIND_NUL)
        begin
            have            = 1'b0;
            ch              = 8'd0;
            count_bumped    = char_count_reg;
            emit            = 1'b1;
        end

        if (q_item.kind == upd_pkg::KIND_NUL || q_item.last)
        begin
            phase_next       = upd_pkg::PH_LOOK;
            high_nibble_next = 4'd0;
            char_count_next  = 16'd0;
        end

        if (!q_rd)
        begin
            phase_next       = phase_reg;
            high_nibble_next = high_nibble_reg;
            char_count_next  = char_count_reg;
        end

        res_valid_next = res_valid_reg;
        if (q_rd && emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (pop)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= upd_pkg::PH_LOOK;
            high_nibble_reg <= 4'd0;
            char_count_reg  <= 16'd0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            high_nibble_reg <= high_nibble_next;
            char_count_reg  <= char_count_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd && emit)
        begin
            res_byte_valid_reg <= have;
            res_byte_reg       <= ch;
            res_term_reg       <= (q_item.kind == upd_pkg::KIND_NUL);
            res_done_reg       <= (q_item.kind == upd_pkg::KIND_NUL) || q_item.last;
            res_length_reg     <= count_bumped;
        end
    end

    assign empty              = !res_valid_reg;
    assign byte_valid         = res_byte_valid_reg;
    assign out_byte           = res_byte_reg;
    assign terminator_written = res_term_reg;
    assign done_res           = res_done_reg;
    assign decoded_length     = res_length_reg;

endmodule

`default_nettype wire

FILE: rtl/url_percent_decoder_top.sv
// An accepted character is registered in the queue, then decoded into the result register.
// Throughput: one character per cycle while full is low; phase and length update per item.
// Up to QUEUE_DEPTH classified characters plus one finished result can wait downstream.
// Reset (rst_n low, asynchronous) empties the queue and result slot, clears form mode,
// returns the escape phase to looking for a percent sign and zeroes the length.
// ----------------------------------------------------------------------------
// url_percent_decoder_top: streaming URL percent-escape decoder
// Decodes one encoded character per transfer into decoded characters, with
// an end-of-string result that carries the decoded length.
// ----------------------------------------------------------------------------
`default_nettype none

module url_percent_decoder_top
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write channel: the form-mode bit.
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic        plus_as_space,
    // Input side, queue style.
    input  wire logic        push,
    output      logic        full,
    input  wire logic [7:0]  in_byte,
    input  wire logic        last_byte,
    // Result side, queue style.
    output      logic        empty,
    input  wire logic        pop,
    output      logic        byte_valid,
    output      logic [7:0]  out_byte,
    output      logic        terminator_written,
    output      logic        done_res,
    output      logic [15:0] decoded_length
);

    // The front part classifies each character on its own: zero byte, percent
    // sign, plus sign in form mode, or anything else, and precomputes its hex
    // value. None of that depends on the escape state, so the front waits on the
    // back only through a full queue.
    logic               q_wr;
    upd_pkg::upd_item_t q_wr_item;
    logic               q_full;
    logic               q_rd;
    logic               q_valid;
    upd_pkg::upd_item_t q_rd_item;

    upd_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .plus_as_space (plus_as_space),
        .push          (push),
        .full          (full),
        .in_byte       (in_byte),
        .last_byte     (last_byte),
        .q_full        (q_full),
        .q_wr          (q_wr),
        .q_wr_item     (q_wr_item)
    );

    // The queue lets the input keep flowing while the consumer stalls the
    // result side, until it fills up.
    upd_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wr_item  (q_wr_item),
        .q_full   (q_full),
        .rd       (q_rd),
        .rd_valid (q_valid),
        .rd_item  (q_rd_item)
    );

    // The back part owns the escape phase, the pending high nibble and the
    // length counter. It drains one item per cycle while its result register
    // is free or being popped in the same cycle. Items that produce no result,
    // such as a percent sign or the first hex digit, are retired without
    // touching the result register.
    upd_back u_back
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .q_valid            (q_valid),
        .q_item             (q_rd_item),
        .q_rd               (q_rd),
        .empty              (empty),
        .pop                (pop),
        .byte_valid         (byte_valid),
        .out_byte           (out_byte),
        .terminator_written (terminator_written),
        .done_res           (done_res),
        .decoded_length     (decoded_length)
    );

endmodule

`default_nettype wire
